[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the date conversion RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, held off while rst_n is low
`define DTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also runs during reset
`define DTE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/dte_pkg.sv]
// ---------------------------------------------------------------------------
// dte_pkg
// Types, constants and tables for the date-string to epoch-seconds block.
// ---------------------------------------------------------------------------
package dte_pkg;

    localparam logic [7:0]  DEFAULT_YEAR_RST = 8'd86;    // years since 1900
    localparam logic [7:0]  CHAR_ZERO        = 8'h30;    // '0'
    localparam logic [7:0]  CHAR_NINE        = 8'h39;    // '9'
    localparam logic [7:0]  CHAR_COLON       = 8'h3A;    // ':'
    localparam logic [7:0]  CHAR_P           = 8'h70;    // 'p'
    localparam logic [7:0]  EPOCH_YEAR       = 8'd70;    // 1970 - 1900
    localparam logic [7:0]  LEAPS_BEFORE_EPOCH = 8'd17;  // (69 >> 2)
    localparam logic [30:0] SEC_MAX          = 31'h7FFF_FFFF;
    localparam int          QUEUE_DEPTH_DEF  = 2;

    // One parsed string, checked and ready for the arithmetic
    typedef struct packed {
        logic       err;
        logic [7:0] year;     // years since 1900
        logic [3:0] month;    // 1..12
        logic [5:0] day;      // 1..32 (32 only after an hour-24 roll)
        logic [4:0] hour;     // 0..23
        logic [5:0] minute;   // 0..59
    } dte_job_t;

    // Days in the months before the given one, non-leap year
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] d;
        d = 9'd0;
        case (month)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[hdl/dte_parser.sv]
// ---------------------------------------------------------------------------
// dte_parser
// Front end: takes one character per request, tracks digit pairs and, on
// the last character, checks the fields and pushes one job to the queue.
// ---------------------------------------------------------------------------
module dte_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   accept,
    input  logic [7:0]             char_code,
    input  logic                   last_char,
    output logic                   push,
    output dte_pkg::dte_job_t      job
);
    import dte_pkg::*;

    localparam logic [3:0] POS_MONTH   = 4'd1;
    localparam logic [3:0] POS_DAY     = 4'd3;
    localparam logic [3:0] POS_HOUR    = 4'd5;
    localparam logic [3:0] POS_MINUTE  = 4'd7;
    localparam logic [3:0] POS_YEAR_HI = 4'd8;   // also the early pm spot
    localparam logic [3:0] POS_YEAR_LO = 4'd9;
    localparam logic [3:0] POS_PM_LATE = 4'd10;
    localparam logic [3:0] POS_MAX     = 4'd15;

    logic [7:0] default_year_reg;
    logic [3:0] pos_reg, pos_next;
    logic [3:0] pfv_reg, pfv_next;
    logic [6:0] month_reg, month_next;
    logic [6:0] day_reg, day_next;
    logic [6:0] hour_reg, hour_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] year_reg, year_next;
    logic       yvalid_reg, yvalid_next;
    logic       pm8_reg, pm8_next;
    logic       pm10_reg, pm10_next;
    logic       ferr_reg, ferr_next;

    logic       ok_first, ok_digit;
    logic [6:0] pair_val;

    assign ok_first = (char_code >= CHAR_ZERO) && (char_code <= CHAR_COLON);
    assign ok_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign pair_val = ok_digit ? (7'({3'b0, pfv_reg} * 7'd10) + {3'b0, char_code[3:0]})
                               : 7'd0;

    // Per-character state update
    always_comb
    begin
        pfv_next    = pfv_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        year_next   = year_reg;
        yvalid_next = yvalid_reg;
        pm8_next    = pm8_reg;
        pm10_next   = pm10_reg;
        ferr_next   = ferr_reg;
        if (pos_reg < POS_PM_LATE)
        begin
            if (!pos_reg[0])
            begin
                pfv_next = ok_first ? char_code[3:0] : 4'd0;
                if (pos_reg == POS_YEAR_HI)
                begin
                    pm8_next    = (char_code == CHAR_P);
                    yvalid_next = ok_first;
                end
                else if (!ok_first)
                begin
                    ferr_next = 1'b1;
                end
            end
            else
            begin
                unique case (pos_reg)
                    POS_MONTH:  month_next  = pair_val;
                    POS_DAY:    day_next    = pair_val;
                    POS_HOUR:   hour_next   = pair_val;
                    POS_MINUTE: minute_next = pair_val;
                    default:    year_next   = pair_val;
                endcase
                if (pos_reg == POS_YEAR_LO)
                    yvalid_next = yvalid_reg && ok_digit;
                else if (!ok_digit)
                    ferr_next = 1'b1;
            end
        end
        else if (pos_reg == POS_PM_LATE)
        begin
            pm10_next = (char_code == CHAR_P);
        end
        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 4'd1;
    end

    // Field checks on the state as it stands after the last character
    logic       yv, pm, err;
    logic [7:0] h_adj;
    logic [6:0] d_adj;

    always_comb
    begin
        yv    = yvalid_next && (pos_next >= POS_PM_LATE);
        pm    = yv ? ((pos_next > POS_PM_LATE) && pm10_next)
                   : ((pos_next > POS_YEAR_HI) && pm8_next);
        err   = ferr_next || (pos_next < POS_YEAR_HI);
        d_adj = day_next;
        h_adj = {1'b0, hour_next};
        if (month_next < 7'd1 || month_next > 7'd12) err = 1'b1;
        if (day_next < 7'd1 || day_next > 7'd31)     err = 1'b1;
        if (hour_next == 7'd24)
        begin
            h_adj = 8'd0;
            d_adj = day_next + 7'd1;
        end
        if (minute_next > 7'd59) err = 1'b1;
        if (pm) h_adj = h_adj + 8'd12;
        if (h_adj > 8'd23) err = 1'b1;

        job.err    = err;
        job.year   = yv ? {1'b0, year_next} : default_year_reg;
        job.month  = month_next[3:0];
        job.day    = d_adj[5:0];
        job.hour   = h_adj[4:0];
        job.minute = minute_next[5:0];
    end

    assign push = accept && last_char;

    // State registers: the parse state is cleared after each string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_year_reg <= DEFAULT_YEAR_RST;
            pos_reg    <= '0;
            pfv_reg    <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            year_reg   <= '0;
            yvalid_reg <= 1'b0;
            pm8_reg    <= 1'b0;
            pm10_reg   <= 1'b0;
            ferr_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                default_year_reg <= cfg_wdata;
            if (accept)
            begin
                if (last_char)
                begin
                    pos_reg    <= '0;
                    pfv_reg    <= '0;
                    month_reg  <= '0;
                    day_reg    <= '0;
                    hour_reg   <= '0;
                    minute_reg <= '0;
                    year_reg   <= '0;
                    yvalid_reg <= 1'b0;
                    pm8_reg    <= 1'b0;
                    pm10_reg   <= 1'b0;
                    ferr_reg   <= 1'b0;
                end
                else
                begin
                    pos_reg    <= pos_next;
                    pfv_reg    <= pfv_next;
                    month_reg  <= month_next;
                    day_reg    <= day_next;
                    hour_reg   <= hour_next;
                    minute_reg <= minute_next;
                    year_reg   <= year_next;
                    yvalid_reg <= yvalid_next;
                    pm8_reg    <= pm8_next;
                    pm10_reg   <= pm10_next;
                    ferr_reg   <= ferr_next;
                end
            end
        end
    end

endmodule

[hdl/dte_queue.sv]
// ---------------------------------------------------------------------------
// dte_queue
// Short job queue between parser and converter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dte_queue #(
    parameter int DEPTH = dte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dte_pkg::dte_job_t      push_job,
    input  logic                   pop,
    output dte_pkg::dte_job_t      head_job,
    output logic                   empty,
    output logic                   full
);
    import dte_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    dte_job_t      mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == DEPTH_CNT);
    assign head_job = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    `DTE_ASSERT(a_no_push_full, push |-> !full, "queue: push while full")
    `DTE_ASSERT(a_no_pop_empty, pop |-> !empty, "queue: pop while empty")
    `DTE_ASSERT(a_count_range, count_reg <= DEPTH_CNT, "queue: count out of range")

endmodule

[hdl/dte_convert.sv]
// ---------------------------------------------------------------------------
// dte_convert
// Back end: turns one checked job into epoch seconds, at most one constant
// multiply per step, and holds the result in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dte_convert (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dte_pkg::dte_job_t      head_job,
    input  logic                   empty,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [30:0]            seconds,
    output logic                   bad_conversion
);
    import dte_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_DAYS,
        ST_HOUR,
        ST_MIN,
        ST_SEC
    } state_t;

    state_t      state_reg, state_next;
    dte_job_t    job_reg, job_next;
    logic [16:0] acc_days_reg, acc_days_next;   // whole years, then all days
    logic [21:0] hours_reg, hours_next;
    logic [26:0] mins_reg, mins_next;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] seconds_reg, seconds_next;
    logic        bad_reg, bad_next;

    logic        out_free;
    logic [32:0] secs_full;
    logic [7:0]  year_cnt;
    logic [7:0]  leap_cnt;
    logic        leap_adj;

    assign out_free  = !out_valid_reg || out_ready;
    assign year_cnt  = job_reg.year - EPOCH_YEAR;
    assign leap_cnt  = ((job_reg.year - 8'd1) >> 2) - LEAPS_BEFORE_EPOCH;
    assign leap_adj  = (job_reg.year[1:0] == 2'b00) && (job_reg.month >= 4'd3);
    assign secs_full = {6'b0, mins_reg} * 33'd60;
    assign pop       = (state_reg == ST_IDLE) && !empty;

    // Step sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        acc_days_next  = acc_days_reg;
        hours_next     = hours_reg;
        mins_next      = mins_reg;
        out_valid_next = out_valid_reg && !out_ready;
        seconds_next   = seconds_reg;
        bad_next       = bad_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    job_next   = head_job;
                    state_next = head_job.err ? ST_SEC : ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                // days in the whole years from 1970
                if (job_reg.year >= EPOCH_YEAR)
                    acc_days_next = 17'({9'b0, year_cnt} * 17'd365) + {9'b0, leap_cnt};
                else
                    acc_days_next = '0;
                state_next = ST_DAYS;
            end
            ST_DAYS:
            begin
                acc_days_next = acc_days_reg + {16'b0, leap_adj}
                              + {8'b0, cum_days(job_reg.month)}
                              + {11'b0, job_reg.day} - 17'd1;
                state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                hours_next = 22'({5'b0, acc_days_reg} * 22'd24) + {17'b0, job_reg.hour};
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                mins_next  = 27'({5'b0, hours_reg} * 27'd60) + {21'b0, job_reg.minute};
                state_next = ST_SEC;
            end
            ST_SEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bad_next       = job_reg.err;
                    if (job_reg.err)
                        seconds_next = '0;
                    else if (secs_full > {2'b0, SEC_MAX})
                        seconds_next = SEC_MAX;
                    else
                        seconds_next = secs_full[30:0];
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        acc_days_reg <= acc_days_next;
        hours_reg    <= hours_next;
        mins_reg     <= mins_next;
        seconds_reg  <= seconds_next;
        bad_reg      <= bad_next;
    end

    assign out_valid      = out_valid_reg;
    assign seconds        = seconds_reg;
    assign bad_conversion = bad_reg;

    `DTE_ASSERT(a_err_zero, (out_valid_reg && bad_reg) |-> (seconds_reg == '0), "convert: error result carries seconds")
    `DTE_ASSERT(a_idle_holds, (state_reg == ST_IDLE && !pop) |=> (state_reg == ST_IDLE), "convert: left idle without a job")
    `DTE_ASSERT(a_no_overwrite, (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(seconds_reg)), "convert: pending result overwritten")

endmodule

[hdl/date_digits_to_epoch_seconds.sv]
// ---------------------------------------------------------------------------
// date_digits_to_epoch_seconds
// Parses an mmddhhmm[yy] ASCII string, one character per request, and
// returns seconds since 1970 or a conversion error on the last character.
//
//   Channel  | Signals                         | Moves
//   ---------+---------------------------------+------------------------------
//   s_       | tvalid tready tdata[7:0] tlast  | one character, tlast = last
//   m_       | tvalid tready tdata[31:0]       | seconds, bad_conversion
//   cfg_     | we wdata[7:0]                   | default year (since 1900)
//
// A character request is taken each cycle while the job queue has room.
// In the converter, each valid string takes a queue pop, four steps of one
// constant multiply or add each, and an output register load that waits
// while a result is pending; a string failing a field check skips the steps.
// Reset is immediate; there is no clearing pass. The output register lets
// the converter park one finished result while the parser keeps taking
// characters, and the queue absorbs strings while the converter is busy.
// ---------------------------------------------------------------------------
module date_digits_to_epoch_seconds #(
    parameter int QUEUE_DEPTH = dte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_code
    input  logic        s_tlast,     // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // [30:0] seconds, [31] bad_conversion
);
    import dte_pkg::*;

    logic     accept, push, pop, empty, full;
    dte_job_t push_job, head_job;
    logic [30:0] seconds;
    logic        bad_conversion;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Front end
    dte_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .push      (push),
        .job       (push_job)
    );

    // Job queue
    dte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    // Back end
    dte_convert u_convert (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .seconds        (seconds),
        .bad_conversion (bad_conversion)
    );

    assign m_tdata = {bad_conversion, seconds};

endmodule

[verif/date_digits_to_epoch_seconds_checker.sv]
// ---------------------------------------------------------------------------
// date_digits_to_epoch_seconds_checker
// Watches the character, result and configuration channels of the date
// converter. Keeps its own parse of each mmddhhmm[yy] string, works out the
// epoch seconds or the conversion error, and compares every result request
// in order against those predictions.
// ---------------------------------------------------------------------------
module date_digits_to_epoch_seconds_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          mismatches,
    output int          awaited
);
    import dte_pkg::*;

    // Character positions with a meaning of their own
    localparam logic [3:0] POS_YEAR = 4'd8;   // first year char, or pm without year
    localparam logic [3:0] POS_YEAR_LOW = 4'd9;
    localparam logic [3:0] POS_PM = 4'd10;    // pm after a valid year
    localparam logic [3:0] POS_SAT = 4'd15;

    typedef struct packed {
        logic        bad;
        logic [30:0] seconds;
    } epoch_result_t;

    int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // Shadow of the register and of the parse
    logic [7:0]    year_default = DEFAULT_YEAR_RST;
    logic [3:0]    position = '0;
    logic [3:0]    tens_digit = '0;
    logic [6:0]    month_v = '0;
    logic [6:0]    day_v = '0;
    logic [6:0]    hour_v = '0;
    logic [6:0]    minute_v = '0;
    logic [6:0]    year_v = '0;
    logic          year_ok = 1'b0;
    logic          pm_eight = 1'b0;
    logic          pm_ten = 1'b0;
    logic          field_bad = 1'b0;
    epoch_result_t pending_epochs [$];
    epoch_result_t want;
    int            fail_n = 0;
    int            wait_n = 0;

    assign mismatches = fail_n;
    assign awaited = wait_n;

    task automatic restart_parse();
        position = '0;
        tens_digit = '0;
        month_v = '0;
        day_v = '0;
        hour_v = '0;
        minute_v = '0;
        year_v = '0;
        year_ok = 1'b0;
        pm_eight = 1'b0;
        pm_ten = 1'b0;
        field_bad = 1'b0;
    endtask

    // Seconds since 1970 for the parsed string, n_chars characters long
    function automatic epoch_result_t convert_date(input int unsigned n_chars);
        epoch_result_t   r;
        logic            err;
        logic            yv;
        logic            pm;
        int unsigned     t;
        int unsigned     d;
        int unsigned     h;
        int unsigned     m;
        int unsigned     y;
        longint unsigned total;
        err = field_bad || n_chars < 8;
        yv = year_ok && n_chars >= 10;
        pm = yv ? (n_chars >= 11 && pm_ten) : (n_chars >= 9 && pm_eight);
        t = month_v;
        d = day_v;
        h = hour_v;
        m = minute_v;
        y = (yv ? int'(year_v) : int'(year_default)) + 1900;
        if (t < 1 || t > 12)
            err = 1'b1;
        if (d < 1 || d > 31)
            err = 1'b1;
        // hour 24 rolls into the next day, day not checked again
        if (h == 24)
        begin
            h = 0;
            d++;
        end
        if (m > 59)
            err = 1'b1;
        if (pm)
            h += 12;
        if (h > 23)
            err = 1'b1;
        total = 0;
        if (!err)
        begin
            // years before 1970 add nothing
            for (int unsigned yr = 1970; yr < y; yr++)
                total += (yr % 4 == 0) ? 366 : 365;
            if (y % 4 == 0 && t >= 3)
                total += 1;
            for (int unsigned mo = 1; mo < t; mo++)
                total += month_len[mo - 1];
            total += d - 1;
            total = ((total * 24 + h) * 60 + m) * 60;
            if (total > longint'(SEC_MAX))
                total = longint'(SEC_MAX);
        end
        r.bad = err;
        r.seconds = err ? '0 : total[30:0];
        return r;
    endfunction

    // One character request into the shadow parse
    task automatic take_char(input logic [7:0] c, input logic last);
        logic       first_ok;
        logic       digit_ok;
        logic [6:0] pair;
        first_ok = c >= CHAR_ZERO && c <= CHAR_COLON;
        digit_ok = c >= CHAR_ZERO && c <= CHAR_NINE;
        pair = digit_ok ? 7'(tens_digit * 10 + (c - CHAR_ZERO)) : '0;
        if (position < POS_PM)
        begin
            if (!position[0])
            begin
                tens_digit = first_ok ? 4'(c - CHAR_ZERO) : '0;
                if (position == POS_YEAR)
                begin
                    pm_eight = (c == CHAR_P);
                    year_ok = first_ok;
                end
                else if (!first_ok)
                    field_bad = 1'b1;
            end
            else
            begin
                case (position)
                    4'd1:    month_v = pair;
                    4'd3:    day_v = pair;
                    4'd5:    hour_v = pair;
                    4'd7:    minute_v = pair;
                    default: year_v = pair;
                endcase
                if (position == POS_YEAR_LOW)
                    year_ok = year_ok && digit_ok;
                else if (!digit_ok)
                    field_bad = 1'b1;
            end
        end
        else if (position == POS_PM)
            pm_ten = (c == CHAR_P);
        if (position < POS_SAT)
            position++;
        if (last)
        begin
            pending_epochs.push_back(convert_date(position));
            restart_parse();
        end
    endtask

    // Results are checked before new characters so a same-edge string
    // never matches its own result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            year_default = DEFAULT_YEAR_RST;
            restart_parse();
            pending_epochs.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_epochs.size() == 0)
                begin
                    fail_n++;
                    $error("unexpected result request: m_tdata expected none, got %h",
                           m_tdata);
                end
                else
                begin
                    want = pending_epochs.pop_front();
                    if (m_tdata[30:0] !== want.seconds)
                    begin
                        fail_n++;
                        $error("seconds: expected %0d, got %0d",
                               want.seconds, m_tdata[30:0]);
                    end
                    if (m_tdata[31] !== want.bad)
                    begin
                        fail_n++;
                        $error("bad_conversion: expected %0b, got %0b",
                               want.bad, m_tdata[31]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_char(s_tdata, s_tlast);
            if (cfg_we)
                year_default = cfg_wdata;
        end
        wait_n = pending_epochs.size();
    end

endmodule

[verif/date_digits_to_epoch_seconds_test.sv]
// ---------------------------------------------------------------------------
// date_digits_to_epoch_seconds_test
// Drives date strings into the converter one character per request, under
// several default years and several patterns of sender gaps and receiver
// stalls, including a long receiver hold-off. The checker beside the block
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module date_digits_to_epoch_seconds_test;
    import dte_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_CHARS = 270;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;        // [7:0] char_code
    logic        s_tlast = 1'b0;      // last_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [30:0] seconds, [31] bad_conversion

    int          fail_total;
    int          awaiting;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_off = 0;
    int          cycle_count = 0;
    logic [7:0]  date_text [$];

    date_digits_to_epoch_seconds DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    date_digits_to_epoch_seconds_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (fail_total),
        .awaited    (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("date_digits_to_epoch_seconds verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is armed
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off--;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one character; returns at the negedge after it was taken
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < date_text.size(); i++)
            send_char(date_text[i], i == date_text.size() - 1);
    endtask

    // Stop offering and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_default_year(input logic [7:0] yr);
        cfg_we <= 1'b1;
        cfg_wdata <= yr;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            date_text.push_back(s[i]);
    endtask

    // Two characters; a tens value of 10 comes out as ':'
    task automatic push_pair(input int v);
        date_text.push_back(8'(CHAR_ZERO + v / 10));
        date_text.push_back(8'(CHAR_ZERO + v % 10));
    endtask

    // Mostly in range, sometimes anything a pair can spell
    function automatic int pick_field(input int lo, input int hi);
        if ($urandom_range(99) < 85)
            return $urandom_range(hi, lo);
        return $urandom_range(109, 0);
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return CHAR_P;
            default: return 8'(CHAR_ZERO + $urandom_range(10));
        endcase
    endfunction

    // Build one date string into date_text
    task automatic make_date_text();
        int cut;
        date_text.delete();
        if ($urandom_range(99) < 75)
        begin
            push_pair(pick_field(1, 12));
            push_pair(pick_field(1, 31));
            push_pair(pick_field(0, 24));
            push_pair(pick_field(0, 59));
            case ($urandom_range(3))
                0: ;
                1: push_pair($urandom_range(99));
                2: push_pair($urandom_range(109));
                default:
                begin
                    date_text.push_back(noise_char());
                    date_text.push_back(noise_char());
                end
            endcase
            if ($urandom_range(99) < 35)
                date_text.push_back(CHAR_P);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(5, 1)) date_text.push_back(8'($urandom_range(255)));
            // one corrupted character
            if ($urandom_range(99) < 8)
                date_text[$urandom_range(date_text.size() - 1)] = 8'($urandom_range(255));
            // string cut short
            if ($urandom_range(99) < 6)
            begin
                cut = $urandom_range(date_text.size() - 1, 1);
                while (date_text.size() > cut)
                    void'(date_text.pop_back());
            end
        end
        else
            repeat ($urandom_range(18, 1)) date_text.push_back(noise_char());
    endtask

    task automatic run_random(input int n_chars);
        int sent;
        sent = 0;
        while (sent < n_chars)
        begin
            make_date_text();
            sent += date_text.size();
            send_text();
            // sender pauses until the block has drained
            if ($urandom_range(39) == 0)
                settle();
        end
        settle();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset default year: year before 1970 with pm after it
        // and ignored trailing characters, hour-24 roll with pm and no year,
        // a string of one NUL
        date_text.delete();
        push_text("0101000000p");
        date_text.push_back(8'hFF);
        send_text();
        date_text.delete();
        push_text("12312459p");
        send_text();
        date_text.delete();
        date_text.push_back(8'h00);
        send_text();
        settle();

        // Lowest default year, no idling
        set_default_year(8'd0);
        run_random(PHASE_CHARS);

        // Highest in-range default year, sender gaps
        set_default_year(8'd137);
        src_idle_pct = 53;
        run_random(PHASE_CHARS);

        // Default year beyond range: saturated seconds; receiver stalls
        set_default_year(8'd255);
        src_idle_pct = 0;
        sink_stall_pct = 53;
        run_random(PHASE_CHARS);

        // Random default year, both sides idle
        set_default_year(8'($urandom_range(136, 1)));
        src_idle_pct = 36;
        sink_stall_pct = 36;
        run_random(PHASE_CHARS);

        // Long receiver hold-off while characters keep coming
        set_default_year(DEFAULT_YEAR_RST);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_off = HOLD_OFF_CYCLES;
        run_random(200);

        if (fail_total == 0 && awaiting == 0)
            $display("date_digits_to_epoch_seconds verification clean");
        else
            $display("date_digits_to_epoch_seconds verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/dte_pkg.sv
hdl/dte_parser.sv
hdl/dte_queue.sv
hdl/dte_convert.sv
hdl/date_digits_to_epoch_seconds.sv
verif/date_digits_to_epoch_seconds_checker.sv
verif/date_digits_to_epoch_seconds_test.sv
